// File: sv/hufc_pkg.sv
// package for the huffman tree codec unit
// types, constants and command codes shared by controller, datapath and top level
// no dependencies
package hufc_pkg;

    localparam int MAX_SYMBOLS = 32;
    localparam int WEIGHT_BITS = 16;
    localparam int NODE_SLOTS  = 2 * MAX_SYMBOLS;
    localparam int NODE_W      = $clog2(NODE_SLOTS);
    localparam int LEAF_W      = $clog2(MAX_SYMBOLS);
    localparam int SUM_W       = WEIGHT_BITS + LEAF_W;
    localparam int NUM_W       = 6;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 31;
    localparam int LEN_W       = 5;
    localparam logic [NUM_W-1:0] NUM_RESET = 6'd27;
    localparam logic [LEN_W-1:0] LEN_MAX   = 5'd31;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_ENCODE = 2'd2,
        OP_DECODE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_BUILT = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD       = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        CMD_NOP     = 5'd0,
        CMD_CAPTURE = 5'd1,
        CMD_LOAD    = 5'd2,
        CMD_BCHK    = 5'd3,
        CMD_BCLR    = 5'd4,
        CMD_MSTART  = 5'd5,
        CMD_MSCAN   = 5'd6,
        CMD_MFIN    = 5'd7,
        CMD_MWA     = 5'd8,
        CMD_MWB     = 5'd9,
        CMD_ESTART  = 5'd10,
        CMD_ESCAN   = 5'd11,
        CMD_EFIN    = 5'd12,
        CMD_ECHK    = 5'd13,
        CMD_EUP     = 5'd14,
        CMD_EBIT    = 5'd15,
        CMD_DRD     = 5'd16,
        CMD_DSEL    = 5'd17,
        CMD_DCH     = 5'd18
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
        logic      in_ready;
        logic      out_load;
    } hufc_cmd_t;

    typedef struct packed {
        op_t  in_op;
        logic built;
        logic bld_bad;
        logic clr_last;
        logic scan_last;
        logic merge_last;
        logic esc_last;
        logic found;
        logic up_done;
        logic dec_leaf;
    } hufc_stat_t;

    typedef struct packed {
        status_t           status;
        logic              symbol_valid;
        logic [SYM_W-1:0]  decoded_symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } hufc_res_t;

endpackage

// File: sv/hufc_ctrl.sv
// controller state machine of the huffman tree codec unit
// sequences load, build, encode and decode; depends on hufc_pkg
module hufc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_free,
    input  hufc_pkg::hufc_stat_t stat,
    output hufc_pkg::hufc_cmd_t  cmd
);
    import hufc_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_LOAD   = 19'h00002,
        S_BCHK   = 19'h00004,
        S_BCLR   = 19'h00008,
        S_MSTART = 19'h00010,
        S_MSCAN  = 19'h00020,
        S_MFIN   = 19'h00040,
        S_MWA    = 19'h00080,
        S_MWB    = 19'h00100,
        S_ESTART = 19'h00200,
        S_ESCAN  = 19'h00400,
        S_EFIN   = 19'h00800,
        S_ECHK   = 19'h01000,
        S_EUP    = 19'h02000,
        S_EBIT   = 19'h04000,
        S_DRD    = 19'h08000,
        S_DSEL   = 19'h10000,
        S_DCH    = 19'h20000,
        S_DONE   = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.code     = CMD_NOP;
        cmd.in_ready = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.code = CMD_CAPTURE;
                    case (stat.in_op)
                        OP_LOAD:   state_next = S_LOAD;
                        OP_BUILD:  state_next = S_BCHK;
                        OP_ENCODE: state_next = stat.built ? S_ESTART : S_DONE;
                        default:   state_next = stat.built ? S_DRD : S_DONE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.code   = CMD_LOAD;
                state_next = S_DONE;
            end
            S_BCHK:
            begin
                cmd.code   = CMD_BCHK;
                state_next = stat.bld_bad ? S_DONE : S_BCLR;
            end
            S_BCLR:
            begin
                cmd.code   = CMD_BCLR;
                state_next = stat.clr_last ? S_MSTART : S_BCLR;
            end
            S_MSTART:
            begin
                cmd.code   = CMD_MSTART;
                state_next = S_MSCAN;
            end
            S_MSCAN:
            begin
                cmd.code   = CMD_MSCAN;
                state_next = stat.scan_last ? S_MFIN : S_MSCAN;
            end
            S_MFIN:
            begin
                cmd.code   = CMD_MFIN;
                state_next = S_MWA;
            end
            S_MWA:
            begin
                cmd.code   = CMD_MWA;
                state_next = S_MWB;
            end
            S_MWB:
            begin
                cmd.code   = CMD_MWB;
                state_next = stat.merge_last ? S_DONE : S_MSTART;
            end
            S_ESTART:
            begin
                cmd.code   = CMD_ESTART;
                state_next = S_ESCAN;
            end
            S_ESCAN:
            begin
                cmd.code   = CMD_ESCAN;
                state_next = stat.esc_last ? S_EFIN : S_ESCAN;
            end
            S_EFIN:
            begin
                cmd.code   = CMD_EFIN;
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                cmd.code   = CMD_ECHK;
                state_next = stat.found ? S_EUP : S_DONE;
            end
            S_EUP:
            begin
                cmd.code   = CMD_EUP;
                state_next = stat.up_done ? S_DONE : S_EBIT;
            end
            S_EBIT:
            begin
                cmd.code   = CMD_EBIT;
                state_next = S_EUP;
            end
            S_DRD:
            begin
                cmd.code   = CMD_DRD;
                state_next = S_DSEL;
            end
            S_DSEL:
            begin
                cmd.code   = CMD_DSEL;
                state_next = stat.dec_leaf ? S_DCH : S_DONE;
            end
            S_DCH:
            begin
                cmd.code   = CMD_DCH;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/hufc_datapath.sv
// datapath of the huffman tree codec unit
// node and leaf memories, scan registers, code accumulator; depends on hufc_pkg
module hufc_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hufc_pkg::hufc_cmd_t           cmd,
    input  hufc_pkg::op_t                 in_op,
    input  logic [hufc_pkg::LEAF_W-1:0]   in_slot,
    input  logic [hufc_pkg::SYM_W-1:0]    in_sym,
    input  logic [hufc_pkg::WEIGHT_BITS-1:0] in_weight,
    input  logic                          in_bit,
    input  logic                          cfg_we,
    input  logic [hufc_pkg::NUM_W-1:0]    cfg_num,
    output hufc_pkg::hufc_stat_t          stat,
    output hufc_pkg::hufc_res_t           res
);
    import hufc_pkg::*;

    logic [SUM_W-1:0]  weight_mem [NODE_SLOTS];
    logic [NODE_W-1:0] parent_mem [NODE_SLOTS];
    logic [NODE_W-1:0] left_mem   [NODE_SLOTS];
    logic [NODE_W-1:0] right_mem  [NODE_SLOTS];
    logic [SYM_W-1:0]  char_mem   [MAX_SYMBOLS];

    logic [SUM_W-1:0]  weight_rd;
    logic [NODE_W-1:0] parent_rd, left_rd, right_rd;
    logic [SYM_W-1:0]  char_rd;

    logic [NUM_W-1:0]       num_reg;
    logic [MAX_SYMBOLS-1:0] loaded_reg;
    logic                   built_reg;
    logic [NUM_W-1:0]       bc_reg;
    logic [NODE_W-1:0]      pos_reg;

    logic [LEAF_W-1:0]      slot_reg;
    logic [SYM_W-1:0]       sym_reg;
    logic [WEIGHT_BITS-1:0] wt_reg;
    logic                   bit_reg;
    logic [NUM_W-1:0]       n_reg;
    logic [NODE_W-1:0]      idx_reg, node_reg, rdx_reg;
    logic [NODE_W-1:0]      a_reg, b_reg, c_reg, f_reg;
    logic [SUM_W-1:0]       w1_reg, w2_reg;
    logic                   rdv_reg, found_reg;
    logic [CODE_W-1:0]      code_reg;
    logic [LEN_W-1:0]       len_reg;
    status_t                st_reg;
    logic                   sv_reg;
    logic [SYM_W-1:0]       dsym_reg;

    logic [NODE_W:0]        total_w, root_w;
    logic [NODE_W-1:0]      total, root, cur, next_node, node_raddr;
    logic [LEAF_W-1:0]      char_raddr;
    logic [MAX_SYMBOLS:0]   one_sh;
    logic [MAX_SYMBOLS-1:0] need_mask;
    logic                   pw_en;
    logic [NODE_W-1:0]      pw_addr, pw_data;

    assign total_w   = {n_reg, 1'b0} - (NODE_W+1)'(1);
    assign total     = total_w[NODE_W-1:0];
    assign root_w    = {bc_reg, 1'b0} - (NODE_W+1)'(1);
    assign root      = root_w[NODE_W-1:0];
    assign cur       = (pos_reg == '0) ? root : pos_reg;
    assign next_node = bit_reg ? right_rd : left_rd;
    assign one_sh    = (MAX_SYMBOLS+1)'(1) << num_reg;
    assign need_mask = one_sh[MAX_SYMBOLS-1:0] - MAX_SYMBOLS'(1);

    always_comb
    begin
        case (cmd.code)
            CMD_ECHK: node_raddr = c_reg;
            CMD_EUP:  node_raddr = parent_rd;
            CMD_EBIT: node_raddr = f_reg;
            CMD_DRD:  node_raddr = cur;
            default:  node_raddr = idx_reg;
        endcase
        if (cmd.code == CMD_DSEL)
        begin
            char_raddr = LEAF_W'(next_node - NODE_W'(1));
        end
        else
        begin
            char_raddr = idx_reg[LEAF_W-1:0];
        end
        pw_en   = 1'b1;
        pw_addr = idx_reg;
        pw_data = '0;
        case (cmd.code)
            CMD_BCLR:
            begin
                pw_addr = idx_reg;
            end
            CMD_MWA:
            begin
                pw_addr = a_reg;
                pw_data = node_reg;
            end
            CMD_MWB:
            begin
                pw_addr = b_reg;
                pw_data = node_reg;
            end
            default:
            begin
                pw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            parent_mem[pw_addr] <= pw_data;
        end
        if (cmd.code == CMD_LOAD)
        begin
            weight_mem[NODE_W'(slot_reg) + NODE_W'(1)] <= SUM_W'(wt_reg);
            char_mem[slot_reg] <= sym_reg;
        end
        if (cmd.code == CMD_MWA)
        begin
            weight_mem[node_reg] <= w1_reg + w2_reg;
            left_mem[node_reg]   <= a_reg;
            right_mem[node_reg]  <= b_reg;
        end
        parent_rd <= parent_mem[node_raddr];
        weight_rd <= weight_mem[node_raddr];
        left_rd   <= left_mem[node_raddr];
        right_rd  <= right_mem[node_raddr];
        char_rd   <= char_mem[char_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg    <= NUM_RESET;
            loaded_reg <= '0;
            built_reg  <= 1'b0;
            bc_reg     <= '0;
            pos_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_reg <= cfg_num;
            end
            case (cmd.code)
                CMD_LOAD:
                begin
                    loaded_reg[slot_reg] <= 1'b1;
                    built_reg            <= 1'b0;
                    pos_reg              <= '0;
                end
                CMD_MWB:
                begin
                    if (node_reg == total)
                    begin
                        built_reg <= 1'b1;
                        bc_reg    <= n_reg;
                        pos_reg   <= '0;
                    end
                end
                CMD_DSEL:
                begin
                    pos_reg <= (NUM_W'(next_node) <= bc_reg) ? '0 : next_node;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.code)
            CMD_CAPTURE:
            begin
                slot_reg <= in_slot;
                sym_reg  <= in_sym;
                wt_reg   <= in_weight;
                bit_reg  <= in_bit;
                code_reg <= '0;
                len_reg  <= '0;
                sv_reg   <= 1'b0;
                dsym_reg <= '0;
                st_reg   <= ((in_op == OP_ENCODE || in_op == OP_DECODE) && !built_reg)
                            ? ST_NOT_BUILT : ST_OK;
            end
            CMD_BCHK:
            begin
                n_reg    <= num_reg;
                idx_reg  <= NODE_W'(1);
                node_reg <= NODE_W'(num_reg) + NODE_W'(1);
                if (stat.bld_bad)
                begin
                    st_reg <= ST_BAD;
                end
            end
            CMD_BCLR:
            begin
                idx_reg <= idx_reg + NODE_W'(1);
            end
            CMD_MSTART:
            begin
                idx_reg <= NODE_W'(1);
                a_reg   <= '0;
                b_reg   <= '0;
                rdv_reg <= 1'b0;
            end
            CMD_MSCAN, CMD_MFIN:
            begin
                idx_reg <= idx_reg + NODE_W'(1);
                rdx_reg <= idx_reg;
                rdv_reg <= (cmd.code == CMD_MSCAN);
                if (rdv_reg && parent_rd == '0)
                begin
                    if (a_reg == '0 || weight_rd <= w1_reg)
                    begin
                        b_reg  <= a_reg;
                        w2_reg <= w1_reg;
                        a_reg  <= rdx_reg;
                        w1_reg <= weight_rd;
                    end
                    else if (b_reg == '0 || weight_rd <= w2_reg)
                    begin
                        b_reg  <= rdx_reg;
                        w2_reg <= weight_rd;
                    end
                end
            end
            CMD_MWB:
            begin
                node_reg <= node_reg + NODE_W'(1);
            end
            CMD_ESTART:
            begin
                idx_reg   <= '0;
                rdv_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            CMD_ESCAN, CMD_EFIN:
            begin
                idx_reg <= idx_reg + NODE_W'(1);
                rdx_reg <= idx_reg;
                rdv_reg <= (cmd.code == CMD_ESCAN);
                if (rdv_reg && !found_reg && char_rd == sym_reg)
                begin
                    found_reg <= 1'b1;
                    c_reg     <= rdx_reg + NODE_W'(1);
                end
            end
            CMD_ECHK:
            begin
                if (!found_reg)
                begin
                    st_reg <= ST_NOT_FOUND;
                end
            end
            CMD_EUP:
            begin
                f_reg <= parent_rd;
            end
            CMD_EBIT:
            begin
                if (right_rd == c_reg)
                begin
                    code_reg <= code_reg | (CODE_W'(1) << len_reg);
                end
                len_reg <= len_reg + LEN_W'(1);
                c_reg   <= f_reg;
            end
            CMD_DSEL:
            begin
                sv_reg <= (NUM_W'(next_node) <= bc_reg);
            end
            CMD_DCH:
            begin
                dsym_reg <= char_rd;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.in_op      = in_op;
    assign stat.built      = built_reg;
    assign stat.bld_bad    = (num_reg < NUM_W'(2)) || (num_reg > NUM_W'(MAX_SYMBOLS))
                             || ((loaded_reg & need_mask) != need_mask);
    assign stat.clr_last   = (idx_reg == total);
    assign stat.scan_last  = (idx_reg == node_reg - NODE_W'(1));
    assign stat.merge_last = (node_reg == total);
    assign stat.esc_last   = (idx_reg == NODE_W'(bc_reg) - NODE_W'(1));
    assign stat.found      = found_reg;
    assign stat.up_done    = (parent_rd == '0) || (len_reg == LEN_MAX);
    assign stat.dec_leaf   = (NUM_W'(next_node) <= bc_reg);

    assign res.status         = st_reg;
    assign res.symbol_valid   = sv_reg;
    assign res.decoded_symbol = dsym_reg;
    assign res.code_bits      = code_reg;
    assign res.code_length    = len_reg;

endmodule

// File: sv/huffman_tree_codec_unit.sv
// top level of the huffman tree codec unit: stream ports, output register
// one item at a time; the next item is taken while a result waits in the output register
// reset (rst_n, async): no leaves loaded, tree not built, num_symbols 27
// depends on hufc_pkg, hufc_ctrl, hufc_datapath
module huffman_tree_codec_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // leaf_index, symbol, weight, code_bit, zero pad
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // decoded_symbol, code_bits, code_length, zero pad
    output logic [2:0]  m_tuser,   // status, symbol_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data   // num_symbols
);
    import hufc_pkg::*;

    hufc_cmd_t  cmd;
    hufc_stat_t stat;
    hufc_res_t  res;
    hufc_res_t  out_reg;
    logic       out_valid_reg;
    logic       out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = cmd.in_ready;

    hufc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    hufc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_op     (op_t'(s_tuser)),
        .in_slot   (s_tdata[4:0]),
        .in_sym    (s_tdata[12:5]),
        .in_weight (s_tdata[28:13]),
        .in_bit    (s_tdata[29]),
        .cfg_we    (cfg_valid),
        .cfg_num   (cfg_data),
        .stat      (stat),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.code_length, out_reg.code_bits, out_reg.decoded_symbol};
    assign m_tuser  = {out_reg.symbol_valid, out_reg.status};

    a_sv_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
        else $error("decoded symbol with error status");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != ST_OK |-> m_tdata[43:39] == 5'd0 && m_tdata[7:0] == 8'd0)
        else $error("error result carries payload");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

// File: tb/tb_huffman_tree_codec_unit.sv
// self-checking testbench for huffman_tree_codec_unit: directed table, then random tree phases
// predicts results from its own tree copy or the table's typed rows; compares beats in order
// depends on hufc_pkg and the huffman_tree_codec_unit rtl
module tb_huffman_tree_codec_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import hufc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // leaf_index, symbol, weight, code_bit, zero pad
    logic [1:0]  s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // decoded_symbol, code_bits, code_length, zero pad
    logic [2:0]  m_tuser;   // status, symbol_valid
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;  // num_symbols

    huffman_tree_codec_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // tree copy
    int unsigned node_wt [NODE_SLOTS];
    int unsigned node_par [NODE_SLOTS];
    int unsigned node_lft [NODE_SLOTS];
    int unsigned node_rgt [NODE_SLOTS];
    logic [SYM_W-1:0] leaf_sym [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] leaf_present;
    bit tree_ready;
    int unsigned walk_node;
    int unsigned leaf_count_reg;
    int unsigned leaf_count_built;

    hufc_res_t pending_results[$];
    int mismatches;
    int items_sent;
    int builds_ok;
    int symbols_decoded;
    int results_seen;
    int send_idle;
    int recv_idle;
    bit hold_req;
    int hold_cnt;

    typedef struct {
        bit               is_cfg;
        logic [NUM_W-1:0] cfg_val;
        op_t              op;
        logic [4:0]       idx;
        logic [7:0]       sym;
        logic [15:0]      wt;
        logic             cbit;
        bit               typed;
        hufc_res_t        res;
    } row_t;

    function automatic hufc_res_t mk_status(status_t st);
        hufc_res_t r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    function automatic int unsigned least_free(int unsigned last, int unsigned skip);
        int unsigned best;
        best = 0;
        for (int unsigned i = 1; i <= last; i++)
        begin
            if (node_par[i] != 0 || i == skip)
                continue;
            if (best == 0 || node_wt[i] <= node_wt[best])
                best = i;
        end
        return best;
    endfunction

    function automatic status_t build_tree();
        int unsigned n;
        int unsigned total;
        int unsigned a;
        int unsigned b;
        n = leaf_count_reg;
        if (n < 2 || n > MAX_SYMBOLS)
            return ST_BAD;
        for (int unsigned i = 0; i < n; i++)
            if (!leaf_present[i])
                return ST_BAD;
        total = 2 * n - 1;
        for (int unsigned i = 1; i <= total; i++)
        begin
            node_par[i] = 0;
            node_lft[i] = 0;
            node_rgt[i] = 0;
            if (i > n)
                node_wt[i] = 0;
        end
        for (int unsigned i = n + 1; i <= total; i++)
        begin
            a = least_free(i - 1, 0);
            b = least_free(i - 1, a);
            node_par[a] = i;
            node_par[b] = i;
            node_lft[i] = a;
            node_rgt[i] = b;
            node_wt[i] = node_wt[a] + node_wt[b];
        end
        leaf_count_built = n;
        tree_ready = 1;
        walk_node = 0;
        builds_ok++;
        return ST_OK;
    endfunction

    function automatic hufc_res_t huff_predict(op_t op, logic [4:0] idx, logic [7:0] sym,
                                               logic [15:0] wt, logic cbit);
        hufc_res_t r;
        int unsigned leaf;
        int unsigned c;
        int unsigned f;
        int unsigned cur;
        int unsigned nxt;
        r = '0;
        if (op == OP_LOAD)
        begin
            leaf_sym[idx] = sym;
            node_wt[idx + 1] = wt;
            leaf_present[idx] = 1'b1;
            tree_ready = 0;
            walk_node = 0;
        end
        else if (op == OP_BUILD)
            r.status = build_tree();
        else if (!tree_ready)
            r.status = ST_NOT_BUILT;
        else if (op == OP_ENCODE)
        begin
            leaf = 0;
            for (int unsigned i = 1; i <= leaf_count_built && leaf == 0; i++)
                if (leaf_sym[i - 1] == sym)
                    leaf = i;
            if (leaf == 0)
                r.status = ST_NOT_FOUND;
            else
            begin
                c = leaf;
                f = node_par[leaf];
                while (f != 0 && r.code_length < LEN_MAX)
                begin
                    if (node_rgt[f] == c)
                        r.code_bits[r.code_length] = 1'b1;
                    r.code_length++;
                    c = f;
                    f = node_par[f];
                end
            end
        end
        else
        begin
            cur = (walk_node == 0) ? 2 * leaf_count_built - 1 : walk_node;
            nxt = cbit ? node_rgt[cur] : node_lft[cur];
            if (nxt <= leaf_count_built)
            begin
                r.symbol_valid = 1'b1;
                r.decoded_symbol = (nxt >= 1) ? leaf_sym[nxt - 1] : '0;
                walk_node = 0;
                symbols_decoded++;
            end
            else
                walk_node = nxt;
        end
        return r;
    endfunction

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #(20ns * 3_000_000);
        $display("huffman_tree_codec_unit test failed");
        $finish;
    end

    // receiver: random stalls plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold_cnt = 400;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        hufc_res_t got;
        hufc_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '0;
            got.status = status_t'(m_tuser[1:0]);
            got.symbol_valid = m_tuser[2];
            got.decoded_symbol = m_tdata[7:0];
            got.code_bits = m_tdata[38:8];
            got.code_length = m_tdata[43:39];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", got);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r || m_tdata[47:44] !== 4'd0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at beat %0d: expected %p, got %p",
                                 results_seen, exp_r, got);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_num_symbols(logic [NUM_W-1:0] v);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        leaf_count_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_beat(op_t op, logic [4:0] idx, logic [7:0] sym, logic [15:0] wt,
                             logic cbit, bit typed, hufc_res_t typed_res);
        hufc_res_t r;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, cbit, wt, sym, idx};
        do
            @(posedge clk);
        while (!s_tready);
        r = huff_predict(op, idx, sym, wt, cbit);
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic send_op(op_t op, logic [4:0] idx, logic [7:0] sym, logic [15:0] wt,
                           logic cbit);
        send_beat(op, idx, sym, wt, cbit, 0, '0);
    endtask

    task automatic tree_phase();
        int n;
        int k;
        int pick;
        logic [NUM_W-1:0] v;
        pick = $urandom_range(99);
        if (pick < 6)
            v = ($urandom_range(1) != 0) ? NUM_W'($urandom_range(1))
                                         : NUM_W'($urandom_range(63, 33));
        else if (pick < 72)
            v = NUM_W'($urandom_range(8, 2));
        else if (pick < 92)
            v = NUM_W'($urandom_range(20, 9));
        else
            v = NUM_W'(MAX_SYMBOLS);
        write_num_symbols(v);
        n = (v > MAX_SYMBOLS) ? MAX_SYMBOLS : v;
        for (int i = 0; i < n; i++)
            if ($urandom_range(24) != 0)
                send_op(OP_LOAD, 5'(i),
                        ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom),
                        ($urandom_range(2) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
                        1'($urandom));
        send_op(OP_BUILD, 5'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
        k = $urandom_range(50, 20);
        for (int j = 0; j < k; j++)
        begin
            pick = $urandom_range(99);
            if (items_sent == 700)
                hold_req = 1;
            if (pick < 45)
                send_op(OP_ENCODE, 5'($urandom),
                        ($urandom_range(4) != 0 && n > 0) ? leaf_sym[$urandom_range(n - 1)]
                                                          : 8'($urandom),
                        16'($urandom), 1'($urandom));
            else if (pick < 92)
                send_op(OP_DECODE, 5'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
            else if (pick < 97)
                send_op(OP_LOAD, 5'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
            else
                send_op(OP_BUILD, 5'($urandom), 8'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        row_t rows[$];
        row_t rw;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_req = 0;
        send_idle = 0;
        recv_idle = 0;
        mismatches = 0;
        items_sent = 0;
        builds_ok = 0;
        symbols_decoded = 0;
        results_seen = 0;
        leaf_present = '0;
        tree_ready = 0;
        walk_node = 0;
        leaf_count_reg = NUM_RESET;
        leaf_count_built = 0;
        for (int i = 0; i < NODE_SLOTS; i++)
        begin
            node_wt[i] = 0;
            node_par[i] = 0;
            node_lft[i] = 0;
            node_rgt[i] = 0;
        end
        for (int i = 0; i < MAX_SYMBOLS; i++)
            leaf_sym[i] = '0;

        //        cfg val op         idx    sym     weight     bit  typed expected
        rows = '{
            '{0, 0,  OP_ENCODE, 5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_NOT_BUILT)},
            '{0, 0,  OP_DECODE, 5'd0,  8'd0,   16'd0,     1'b1, 1, mk_status(ST_NOT_BUILT)},
            '{0, 0,  OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_BAD)},
            '{1, 0,  OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_BAD)},
            '{1, 63, OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_BAD)},
            '{1, 33, OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_BAD)},
            '{1, 1,  OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_BAD)},
            '{1, 2,  OP_LOAD,   5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_OK)},
            '{0, 0,  OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_BAD)},
            '{0, 0,  OP_LOAD,   5'd1,  8'd255, 16'hffff,  1'b1, 1, mk_status(ST_OK)},
            '{0, 0,  OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_OK)},
            '{0, 0,  OP_ENCODE, 5'd0,  8'd0,   16'd0,     1'b0, 0, '0},
            '{0, 0,  OP_ENCODE, 5'd31, 8'd255, 16'hffff,  1'b1, 0, '0},
            '{0, 0,  OP_ENCODE, 5'd0,  8'd7,   16'd0,     1'b0, 1, mk_status(ST_NOT_FOUND)},
            '{0, 0,  OP_DECODE, 5'd0,  8'd0,   16'd0,     1'b0, 0, '0},
            '{0, 0,  OP_DECODE, 5'd0,  8'd0,   16'd0,     1'b1, 0, '0},
            '{0, 0,  OP_LOAD,   5'd31, 8'haa,  16'hffff,  1'b1, 1, mk_status(ST_OK)},
            '{0, 0,  OP_ENCODE, 5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_NOT_BUILT)},
            '{0, 0,  OP_DECODE, 5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_NOT_BUILT)},
            '{0, 0,  OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_OK)},
            '{0, 0,  OP_DECODE, 5'd0,  8'd0,   16'd0,     1'b1, 0, '0},
            '{1, 32, OP_BUILD,  5'd0,  8'd0,   16'd0,     1'b0, 1, mk_status(ST_BAD)}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.is_cfg)
                write_num_symbols(rw.cfg_val);
            send_beat(rw.op, rw.idx, rw.sym, rw.wt, rw.cbit, rw.typed, rw.res);
        end

        send_idle = 18;
        recv_idle = 86;
        while (items_sent < 1320)
        begin
            if (items_sent > 460 && send_idle == 18)
            begin
                send_idle = 86;
                recv_idle = 18;
            end
            else if (items_sent > 900 && send_idle == 86)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (items_sent > 690 && items_sent < 760)
                hold_req = 1;
            tree_phase();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d items sent, %0d results checked, %0d trees built, %0d symbols decoded",
                 items_sent, results_seen, builds_ok, symbols_decoded);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("huffman_tree_codec_unit test passed");
        else
            $display("huffman_tree_codec_unit test failed");
        $finish;
    end
endmodule

// File: files.f
sv/hufc_pkg.sv
sv/hufc_ctrl.sv
sv/hufc_datapath.sv
sv/huffman_tree_codec_unit.sv
tb/tb_huffman_tree_codec_unit.sv
